>>> sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro takes a label, a clock, an active-low reset and the terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/odht_pkg.sv
// package for the object dictionary hash table: sizes, codes, entry layout
// and the value fitting function; no dependencies
`default_nettype none

package odht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int CFG_W       = 9;
    localparam int IDX_W       = 16;
    localparam int SUB_W       = 8;
    localparam int HASH_MULT   = 31;
    localparam int HASH_W      = 21;
    localparam int VAL_W       = 32;
    localparam int TYPE_W      = 3;
    localparam int ATTR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int OP_W        = 2;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = CFG_W'(256);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_BOOL        = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_U8          = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_U16         = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_U32         = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_I8          = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_I16         = 3'd5;
    localparam logic [TYPE_W-1:0] TYPE_I32         = 3'd6;
    localparam logic [TYPE_W-1:0] TYPE_UNSUPPORTED = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_OVERWRITTEN = 3'd1,
        ST_COLLISION   = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_UNSUPPORTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0]  key_index;
        logic [TYPE_W-1:0] data_type;
        logic [ATTR_W-1:0] access;
        logic [ATTR_W-1:0] persist;
        logic [VAL_W-1:0]  value;
    } entry_t;

    // truncate to the type, then zero- or sign-extend back to full width
    function automatic logic [VAL_W-1:0] fit_to_type(
        input logic [TYPE_W-1:0] t,
        input logic [VAL_W-1:0]  v
    );
        logic [VAL_W-1:0] r;
        case (t) inside
            TYPE_BOOL, TYPE_U8: r = {{(VAL_W-8){1'b0}}, v[7:0]};
            TYPE_U16:           r = {{(VAL_W-16){1'b0}}, v[15:0]};
            TYPE_I8:            r = {{(VAL_W-8){v[7]}}, v[7:0]};
            TYPE_I16:           r = {{(VAL_W-16){v[15]}}, v[15:0]};
            default:            r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/odht_if.sv
// valid/ready channel interfaces for request and result transactions
// depends on odht_pkg for field widths
`default_nettype none

interface odht_in_if;
    logic                            valid;
    logic                            ready;
    logic [odht_pkg::OP_W-1:0]       operation;
    logic [odht_pkg::IDX_W-1:0]      od_index;
    logic [odht_pkg::SUB_W-1:0]      od_subindex;
    logic [odht_pkg::TYPE_W-1:0]     data_type;
    logic [odht_pkg::ATTR_W-1:0]     access_bits;
    logic [odht_pkg::ATTR_W-1:0]     persist_flag;
    logic signed [odht_pkg::VAL_W-1:0] data_value;

    modport source (
        output valid, operation, od_index, od_subindex, data_type,
               access_bits, persist_flag, data_value,
        input  ready
    );
    modport sink (
        input  valid, operation, od_index, od_subindex, data_type,
               access_bits, persist_flag, data_value,
        output ready
    );
endinterface

interface odht_out_if;
    logic                              valid;
    logic                              ready;
    logic [odht_pkg::STATUS_W-1:0]     status;
    logic [odht_pkg::SLOT_W-1:0]       slot;
    logic signed [odht_pkg::VAL_W-1:0] read_value;
    logic [odht_pkg::TYPE_W-1:0]       stored_type;
    logic [odht_pkg::ATTR_W-1:0]       stored_access;
    logic [odht_pkg::ATTR_W-1:0]       stored_persist;

    modport source (
        output valid, status, slot, read_value, stored_type, stored_access,
               stored_persist,
        input  ready
    );
    modport sink (
        input  valid, status, slot, read_value, stored_type, stored_access,
               stored_persist,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/object_dictionary_hash_table.sv
// object dictionary hash table: a request passes through the divider steps, takes the
// remainder as its slot, then the memory read and the execute state before result valid
// one transaction in flight at a time, set by the bit-serial modulo unit
// a stalled result lets one more request in, which waits in the execute state, input not ready
// reset clears all slot valid bits at once and sets the slot count to 256
// depends on odht_pkg, odht_if and odht_divider
`default_nettype none

module object_dictionary_hash_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [odht_pkg::CFG_W-1:0] cfg_wr_data,
    odht_in_if.sink                         in_ch,
    odht_out_if.source                      out_ch
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EXEC
    } state_t;

    state_t state_reg;

    // configuration: number of slots in use, modulus of the hash
    logic [odht_pkg::CFG_W-1:0] slot_count_reg;

    // request fields held for the duration of the transaction
    logic [odht_pkg::OP_W-1:0]   op_reg;
    logic [odht_pkg::IDX_W-1:0]  idx_reg;
    logic [odht_pkg::TYPE_W-1:0] type_reg;
    logic [odht_pkg::ATTR_W-1:0] acc_reg;
    logic [odht_pkg::ATTR_W-1:0] per_reg;
    logic [odht_pkg::VAL_W-1:0]  val_reg;
    logic [odht_pkg::SLOT_W-1:0] slot_reg;

    // slot valid bits live in flops so reset empties the table at once
    logic [odht_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic                             hit_reg;

    // entry memory: one read or one write port per cycle, read data registered
    odht_pkg::entry_t mem [odht_pkg::TABLE_DEPTH];
    odht_pkg::entry_t rd_entry_reg;
    logic             mem_re;
    logic             mem_we;
    odht_pkg::entry_t mem_wdata;

    // result register, parts the pipeline from the output handshake
    logic                          out_valid_reg;
    odht_pkg::status_t             status_reg;
    logic [odht_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [odht_pkg::VAL_W-1:0]    read_value_reg;
    logic [odht_pkg::TYPE_W-1:0]   stored_type_reg;
    logic [odht_pkg::ATTR_W-1:0]   stored_access_reg;
    logic [odht_pkg::ATTR_W-1:0]   stored_persist_reg;

    // divider hookup
    logic                          in_fire;
    logic                          div_done;
    logic [odht_pkg::SIZE_W-1:0]   div_rem;
    logic [odht_pkg::HASH_W-1:0]   hash;
    logic [odht_pkg::SIZE_W-1:0]   size_in_use;

    // execute-stage decisions
    logic                          out_free;
    logic                          exec_fire;
    odht_pkg::status_t             status_next;
    logic                          show;
    odht_pkg::entry_t              shown;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign exec_fire   = (state_reg == S_EXEC) && out_free;
    assign mem_re      = (state_reg == S_READ);

    // index*31 + subindex, always below 2^21
    assign hash = odht_pkg::HASH_W'(in_ch.od_index) * odht_pkg::HASH_W'(odht_pkg::HASH_MULT)
                + odht_pkg::HASH_W'(in_ch.od_subindex);

    // zero acts as one, anything above the depth acts as the depth
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            size_in_use = odht_pkg::SIZE_W'(1);
        end
        else if (32'(slot_count_reg) > 32'(odht_pkg::TABLE_DEPTH))
        begin
            size_in_use = odht_pkg::SIZE_W'(odht_pkg::TABLE_DEPTH);
        end
        else
        begin
            size_in_use = odht_pkg::SIZE_W'(slot_count_reg);
        end
    end

    odht_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire),
        .dividend  (hash),
        .divisor   (size_in_use),
        .done      (div_done),
        .remainder (div_rem)
    );

    // read-modify-write decision on the entry fetched for this slot
    always_comb
    begin
        status_next = odht_pkg::ST_OK;
        show        = 1'b1;
        shown       = rd_entry_reg;
        mem_we      = 1'b0;
        mem_wdata   = rd_entry_reg;
        case (op_reg)
            odht_pkg::OP_INSERT:
            begin
                if (hit_reg && (rd_entry_reg.key_index != idx_reg))
                begin
                    // another index owns the slot, leave it alone
                    status_next = odht_pkg::ST_COLLISION;
                end
                else if (type_reg == odht_pkg::TYPE_UNSUPPORTED)
                begin
                    status_next = odht_pkg::ST_UNSUPPORTED;
                    show        = hit_reg;
                end
                else
                begin
                    // same index or empty slot: a different subindex is replaced too
                    status_next         = hit_reg ? odht_pkg::ST_OVERWRITTEN
                                                  : odht_pkg::ST_OK;
                    mem_we              = exec_fire;
                    mem_wdata.key_index = idx_reg;
                    mem_wdata.data_type = type_reg;
                    mem_wdata.access    = acc_reg;
                    mem_wdata.persist   = per_reg;
                    mem_wdata.value     = odht_pkg::fit_to_type(type_reg, val_reg);
                    shown               = mem_wdata;
                end
            end
            odht_pkg::OP_WRITE:
            begin
                if (!hit_reg)
                begin
                    status_next = odht_pkg::ST_EMPTY;
                    show        = 1'b0;
                end
                else if (rd_entry_reg.data_type == odht_pkg::TYPE_UNSUPPORTED)
                begin
                    status_next = odht_pkg::ST_UNSUPPORTED;
                end
                else
                begin
                    // key is not checked, the stored type decides the width
                    mem_we          = exec_fire;
                    mem_wdata.value = odht_pkg::fit_to_type(rd_entry_reg.data_type, val_reg);
                    shown           = mem_wdata;
                end
            end
            default:
            begin
                // read, and the spare opcode behaves as a read
                if (!hit_reg)
                begin
                    status_next = odht_pkg::ST_EMPTY;
                    show        = 1'b0;
                end
            end
        endcase
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_entry_reg <= mem[slot_reg];
        end
    end

    // control, valid bits and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            slot_count_reg     <= odht_pkg::SLOT_COUNT_RESET;
            valid_reg          <= '0;
            hit_reg            <= 1'b0;
            op_reg             <= '0;
            idx_reg            <= '0;
            type_reg           <= '0;
            acc_reg            <= '0;
            per_reg            <= '0;
            val_reg            <= '0;
            slot_reg           <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= odht_pkg::ST_OK;
            out_slot_reg       <= '0;
            read_value_reg     <= '0;
            stored_type_reg    <= '0;
            stored_access_reg  <= '0;
            stored_persist_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                slot_count_reg <= cfg_wr_data;
            end

            // result taken and no new one loaded this cycle
            if (out_valid_reg && out_ch.ready && !exec_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= in_ch.operation;
                        idx_reg   <= in_ch.od_index;
                        type_reg  <= in_ch.data_type;
                        acc_reg   <= in_ch.access_bits;
                        per_reg   <= in_ch.persist_flag;
                        val_reg   <= in_ch.data_value;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        // remainder is below the size in use, so it fits a slot number
                        slot_reg  <= div_rem[odht_pkg::SLOT_W-1:0];
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    hit_reg   <= valid_reg[slot_reg];
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        if (mem_we)
                        begin
                            valid_reg[slot_reg] <= 1'b1;
                        end
                        out_valid_reg      <= 1'b1;
                        status_reg         <= status_next;
                        out_slot_reg       <= slot_reg;
                        read_value_reg     <= show ? shown.value : '0;
                        stored_type_reg    <= show ? shown.data_type : '0;
                        stored_access_reg  <= show ? shown.access : '0;
                        stored_persist_reg <= show ? shown.persist : '0;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.slot           = out_slot_reg;
    assign out_ch.read_value     = read_value_reg;
    assign out_ch.stored_type    = stored_type_reg;
    assign out_ch.stored_access  = stored_access_reg;
    assign out_ch.stored_persist = stored_persist_reg;

endmodule

`default_nettype wire

>>> sv/odht_divider.sv
// restoring divider, one quotient bit per cycle, remainder only
// depends on odht_pkg for the hash and size widths
`default_nettype none

module odht_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [odht_pkg::HASH_W-1:0]   dividend,
    input  wire logic [odht_pkg::SIZE_W-1:0]   divisor,
    output logic                               done,
    output logic [odht_pkg::SIZE_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(odht_pkg::HASH_W + 1);

    logic [odht_pkg::HASH_W-1:0] dvd_reg;
    logic [odht_pkg::SIZE_W-1:0] dvs_reg;
    logic [odht_pkg::SIZE_W-1:0] rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [odht_pkg::SIZE_W:0]   trial;
    logic [odht_pkg::SIZE_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[odht_pkg::HASH_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = odht_pkg::SIZE_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[odht_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(odht_pkg::HASH_W);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                dvd_reg  <= {dvd_reg[odht_pkg::HASH_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                // last step: remainder is final on the next cycle
                busy_reg <= (cnt_reg != CNT_W'(1));
                done_reg <= (cnt_reg == CNT_W'(1));
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> sv/odht_checker.sv
// port-level checker for the object dictionary hash table, bound to the top level
// depends on odht_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module odht_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [odht_pkg::STATUS_W-1:0] status,
    input wire logic [odht_pkg::SLOT_W-1:0]   slot,
    input wire logic [odht_pkg::VAL_W-1:0]    read_value,
    input wire logic [odht_pkg::TYPE_W-1:0]   stored_type,
    input wire logic [odht_pkg::ATTR_W-1:0]   stored_access,
    input wire logic [odht_pkg::ATTR_W-1:0]   stored_persist
);

    localparam int PAYLOAD_W = odht_pkg::STATUS_W + odht_pkg::SLOT_W + odht_pkg::VAL_W
                             + odht_pkg::TYPE_W + 2 * odht_pkg::ATTR_W;

    logic                 stall;
    logic                 is_empty;
    logic                 is_collision;
    logic                 fields_zero;
    logic                 status_ok;
    logic [PAYLOAD_W-1:0] payload;

    assign stall        = out_valid && !out_ready;
    assign is_empty     = out_valid
                        && (status == odht_pkg::STATUS_W'(odht_pkg::ST_EMPTY));
    assign is_collision = out_valid
                        && (status == odht_pkg::STATUS_W'(odht_pkg::ST_COLLISION));
    assign fields_zero  = (read_value == '0) && (stored_type == '0)
                        && (stored_access == '0) && (stored_persist == '0);
    assign status_ok    = (status <= odht_pkg::STATUS_W'(odht_pkg::ST_UNSUPPORTED));
    assign payload      = {status, slot, read_value, stored_type, stored_access,
                           stored_persist};

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid)

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, stall, $stable(payload))

    // only the five defined status codes leave the block
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, out_valid, status_ok)

    // an empty slot reports no entry contents
    `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, is_empty, fields_zero)

    // a collision shows a stored entry, and no entry is ever stored with the unsupported type
    `ASSERT_IMPLIES(a_collision_shows_entry, clk, rst_n, is_collision, stored_type != 3'd7)

endmodule

bind object_dictionary_hash_table odht_checker u_odht_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .status         (out_ch.status),
    .slot           (out_ch.slot),
    .read_value     (out_ch.read_value),
    .stored_type    (out_ch.stored_type),
    .stored_access  (out_ch.stored_access),
    .stored_persist (out_ch.stored_persist)
);

`default_nettype wire

>>> tb/sv/object_dictionary_hash_table_test.sv
`timescale 1ns / 1ps
// self-checking testbench for object_dictionary_hash_table: a directed table, then random
// sequences of insert, read and write; depends on odht_pkg, odht_if and the block itself

module object_dictionary_hash_table_test;

    // operation code 3 has no name in the package; the block treats it as a read
    localparam logic [odht_pkg::OP_W-1:0] OP_ALIAS_READ = 2'd3;

    typedef struct packed {
        logic [odht_pkg::OP_W-1:0]   operation;
        logic [odht_pkg::IDX_W-1:0]  od_index;
        logic [odht_pkg::SUB_W-1:0]  od_subindex;
        logic [odht_pkg::TYPE_W-1:0] data_type;
        logic [odht_pkg::ATTR_W-1:0] access_bits;
        logic [odht_pkg::ATTR_W-1:0] persist_flag;
        logic [odht_pkg::VAL_W-1:0]  data_value;
    } request_t;

    typedef struct packed {
        odht_pkg::status_t           status;
        logic [odht_pkg::SLOT_W-1:0] slot;
        logic [odht_pkg::VAL_W-1:0]  read_value;
        logic [odht_pkg::TYPE_W-1:0] stored_type;
        logic [odht_pkg::ATTR_W-1:0] stored_access;
        logic [odht_pkg::ATTR_W-1:0] stored_persist;
    } answer_t;

    // a directed row either resizes the table, carries a typed-in reply, or leans on
    // the predictor
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_KNOWN,
        ROW_RESIZE
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        request_t  stim;
        answer_t   known;
    } stim_row_t;

    localparam answer_t NO_REPLY = '0;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [odht_pkg::CFG_W-1:0] cfg_wr_data;

    odht_in_if  req_bus ();
    odht_out_if rsp_bus ();

    object_dictionary_hash_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (req_bus),
        .out_ch      (rsp_bus)
    );

    // ------------------------------------------------------------------
    // shadow copy of the table, kept in step with accepted requests
    // ------------------------------------------------------------------
    bit                          tbl_used    [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::IDX_W-1:0]  tbl_index   [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::TYPE_W-1:0] tbl_type    [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::ATTR_W-1:0] tbl_access  [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::ATTR_W-1:0] tbl_persist [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::VAL_W-1:0]  tbl_value   [odht_pkg::TABLE_DEPTH];
    logic [odht_pkg::CFG_W-1:0]  tbl_size = odht_pkg::SLOT_COUNT_RESET;

    // replies still owed by the block, oldest first
    answer_t   pending_replies [$];
    // keys recently inserted, so that reads and writes land on live slots
    logic [odht_pkg::IDX_W+odht_pkg::SUB_W-1:0] live_keys [$];
    stim_row_t rows [$];

    int fail_count;
    int replies_seen;
    int size_settings;
    int ops_issued  [4];
    int status_seen [8];

    // pacing controls: burst length left on the sender, stall pattern on the receiver
    bit tx_steady;
    bit rx_steady;
    int burst_left;
    int rx_hold;
    bit rx_open;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // cut the value down to its type, then widen it back with zero or sign fill
    function automatic logic [odht_pkg::VAL_W-1:0] narrow_value(
        input logic [odht_pkg::TYPE_W-1:0] t,
        input logic [odht_pkg::VAL_W-1:0]  v
    );
        logic [odht_pkg::VAL_W-1:0] r;
        case (t)
            odht_pkg::TYPE_BOOL, odht_pkg::TYPE_U8:
                r = v & 32'h0000_00ff;
            odht_pkg::TYPE_U16:
                r = v & 32'h0000_ffff;
            odht_pkg::TYPE_I8:
                r = v[7] ? (v | 32'hffff_ff00) : (v & 32'h0000_00ff);
            odht_pkg::TYPE_I16:
                r = v[15] ? (v | 32'hffff_0000) : (v & 32'h0000_ffff);
            default:
                r = v;
        endcase
        return r;
    endfunction

    // hash the key, apply the operation to the shadow table, return the reply
    function automatic answer_t predict_table_op(input request_t r);
        answer_t                     a;
        int unsigned                 modulus;
        int unsigned                 idx_u;
        int unsigned                 sub_u;
        int unsigned                 hashed;
        logic [odht_pkg::SLOT_W-1:0] s;
        bit                          show;
        modulus = tbl_size;
        if (modulus == 0)
            modulus = 1;
        if (modulus > odht_pkg::TABLE_DEPTH)
            modulus = odht_pkg::TABLE_DEPTH;
        idx_u  = r.od_index;
        sub_u  = r.od_subindex;
        hashed = (idx_u * odht_pkg::HASH_MULT + sub_u) % modulus;
        s      = odht_pkg::SLOT_W'(hashed);
        a      = '0;
        a.slot = s;
        show   = 1'b0;
        if (r.operation == odht_pkg::OP_INSERT)
        begin
            // a foreign index in the slot wins over every other check
            if (tbl_used[s] && tbl_index[s] != r.od_index)
            begin
                a.status = odht_pkg::ST_COLLISION;
                show     = 1'b1;
            end
            else if (r.data_type == odht_pkg::TYPE_UNSUPPORTED)
            begin
                a.status = odht_pkg::ST_UNSUPPORTED;
                show     = tbl_used[s];
            end
            else
            begin
                // same index with any subindex simply replaces the entry
                a.status       = tbl_used[s] ? odht_pkg::ST_OVERWRITTEN : odht_pkg::ST_OK;
                tbl_used[s]    = 1'b1;
                tbl_index[s]   = r.od_index;
                tbl_type[s]    = r.data_type;
                tbl_access[s]  = r.access_bits;
                tbl_persist[s] = r.persist_flag;
                tbl_value[s]   = narrow_value(r.data_type, r.data_value);
                show           = 1'b1;
            end
        end
        else if (!tbl_used[s])
        begin
            a.status = odht_pkg::ST_EMPTY;
        end
        else
        begin
            // the key is not compared: whatever entry holds the slot answers
            show = 1'b1;
            if (r.operation == odht_pkg::OP_WRITE)
            begin
                if (tbl_type[s] == odht_pkg::TYPE_UNSUPPORTED)
                    a.status = odht_pkg::ST_UNSUPPORTED;
                else
                    tbl_value[s] = narrow_value(tbl_type[s], r.data_value);
            end
        end
        if (show)
        begin
            a.read_value     = tbl_value[s];
            a.stored_type    = tbl_type[s];
            a.stored_access  = tbl_access[s];
            a.stored_persist = tbl_persist[s];
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // table row builders
    // ------------------------------------------------------------------
    function automatic request_t req(
        input logic [odht_pkg::OP_W-1:0]   op,
        input logic [odht_pkg::IDX_W-1:0]  idx,
        input logic [odht_pkg::SUB_W-1:0]  sub,
        input logic [odht_pkg::TYPE_W-1:0] t,
        input logic [odht_pkg::ATTR_W-1:0] acc,
        input logic [odht_pkg::ATTR_W-1:0] per,
        input logic [odht_pkg::VAL_W-1:0]  v
    );
        request_t r;
        r.operation    = op;
        r.od_index     = idx;
        r.od_subindex  = sub;
        r.data_type    = t;
        r.access_bits  = acc;
        r.persist_flag = per;
        r.data_value   = v;
        return r;
    endfunction

    function automatic answer_t reply(
        input odht_pkg::status_t           st,
        input logic [odht_pkg::SLOT_W-1:0] sl,
        input logic [odht_pkg::VAL_W-1:0]  v,
        input logic [odht_pkg::TYPE_W-1:0] t,
        input logic [odht_pkg::ATTR_W-1:0] acc,
        input logic [odht_pkg::ATTR_W-1:0] per
    );
        answer_t a;
        a.status         = st;
        a.slot           = sl;
        a.read_value     = v;
        a.stored_type    = t;
        a.stored_access  = acc;
        a.stored_persist = per;
        return a;
    endfunction

    function automatic request_t random_request(input bit narrow_keys);
        request_t r;
        r.operation    = odht_pkg::OP_W'($urandom_range(0, 3));
        r.od_index     = narrow_keys ? odht_pkg::IDX_W'($urandom_range(0, 63))
                                     : odht_pkg::IDX_W'($urandom);
        r.od_subindex  = odht_pkg::SUB_W'($urandom);
        r.data_type    = odht_pkg::TYPE_W'($urandom);
        r.access_bits  = odht_pkg::ATTR_W'($urandom);
        r.persist_flag = odht_pkg::ATTR_W'($urandom);
        r.data_value   = $urandom;
        // now and then a value at the edges of the range
        case ($urandom_range(0, 15))
            0:       r.data_value = 32'h0000_0000;
            1:       r.data_value = 32'hffff_ffff;
            2:       r.data_value = 32'h8000_0000;
            3:       r.data_value = 32'h7fff_ffff;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // drive one transaction, wait for the handshake, record what should come back;
    // valid is left high so a burst carries straight on
    task automatic issue_request(input request_t r, input bit typed, input answer_t want);
        answer_t predicted;
        req_bus.valid        <= 1'b1;
        req_bus.operation    <= r.operation;
        req_bus.od_index     <= r.od_index;
        req_bus.od_subindex  <= r.od_subindex;
        req_bus.data_type    <= r.data_type;
        req_bus.access_bits  <= r.access_bits;
        req_bus.persist_flag <= r.persist_flag;
        req_bus.data_value   <= r.data_value;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = predict_table_op(r);
        pending_replies.push_back(typed ? want : predicted);
        ops_issued[r.operation]++;
        // bursty sender: a random gap once the current burst runs out
        if (!tx_steady)
        begin
            if (burst_left == 0)
            begin
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
                burst_left = $urandom_range(1, 8);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // hold the sender off until every owed reply is back
    task automatic drain_replies();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
        repeat (4)
            @(posedge clk);
    endtask

    // the slot count may only change while the block has nothing in flight
    task automatic set_table_size(input logic [odht_pkg::CFG_W-1:0] size);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tbl_size   = size;
        size_settings++;
    endtask

    // mostly well-formed traffic: insert a key, then read and write it; the rest is
    // re-inserts under a live index and plain noise
    task automatic run_random_phase(input logic [odht_pkg::CFG_W-1:0] size, input int count,
                                    input bit narrow_keys, input bit steady);
        request_t                                   r;
        int                                         pick;
        logic [odht_pkg::IDX_W+odht_pkg::SUB_W-1:0] key;
        set_table_size(size);
        tx_steady = steady;
        rx_steady = steady;
        for (int n = 0; n < count; n++)
        begin
            r    = random_request(narrow_keys);
            pick = $urandom_range(0, 99);
            if (live_keys.size() == 0 || pick < 30)
            begin
                // fresh entry
                r.operation = odht_pkg::OP_INSERT;
                live_keys.push_back({r.od_index, r.od_subindex});
                if (live_keys.size() > 16)
                    void'(live_keys.pop_front());
            end
            else if (pick < 80)
            begin
                // follow-up on a live key
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                {r.od_index, r.od_subindex} = key;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: r.operation = odht_pkg::OP_WRITE;
                    4, 5, 6, 7: r.operation = odht_pkg::OP_READ;
                    8:          r.operation = OP_ALIAS_READ;
                    default:    r.operation = odht_pkg::OP_INSERT;
                endcase
            end
            else if (pick < 90)
            begin
                // live index with a new subindex: overwrite or a new slot
                key         = live_keys[$urandom_range(0, live_keys.size() - 1)];
                r.od_index  = key[odht_pkg::IDX_W+odht_pkg::SUB_W-1:odht_pkg::SUB_W];
                r.operation = odht_pkg::OP_INSERT;
            end
            // otherwise every field stays random
            if ($urandom_range(0, 199) == 0)
                drain_replies();
            issue_request(r, 1'b0, NO_REPLY);
        end
    endtask

    // ------------------------------------------------------------------
    // reply side: stall pattern and checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [odht_pkg::VAL_W-1:0] want,
                                 input logic [odht_pkg::VAL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : reply_monitor
        answer_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            replies_seen++;
            status_seen[rsp_bus.status]++;
            if (pending_replies.size() == 0)
            begin
                $error("reply transaction with nothing outstanding, status %0d slot %0d",
                       rsp_bus.status, rsp_bus.slot);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_field("status", want.status, rsp_bus.status);
                compare_field("slot", want.slot, rsp_bus.slot);
                compare_field("read_value", want.read_value, rsp_bus.read_value);
                compare_field("stored_type", want.stored_type, rsp_bus.stored_type);
                compare_field("stored_access", want.stored_access, rsp_bus.stored_access);
                compare_field("stored_persist", want.stored_persist, rsp_bus.stored_persist);
            end
        end
        // receiver alternates open and stalled stretches of random length
        if (rx_hold == 0)
        begin
            rx_open = rx_steady ? 1'b1 : ($urandom_range(0, 99) < 65);
            rx_hold = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 15);
        end
        rx_hold--;
        rsp_bus.ready <= rx_open;
    end

    // ------------------------------------------------------------------
    // clock, watchdog, main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // worst correct run is well under half a millisecond
    initial
    begin
        #3_000_000;
        $display("timeout with %0d replies outstanding", pending_replies.size());
        $display("FAIL object_dictionary_hash_table");
        $finish;
    end

    initial
    begin
        // every block input known from time zero
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        req_bus.valid        <= 1'b0;
        req_bus.operation    <= odht_pkg::OP_INSERT;
        req_bus.od_index     <= '0;
        req_bus.od_subindex  <= '0;
        req_bus.data_type    <= odht_pkg::TYPE_BOOL;
        req_bus.access_bits  <= '0;
        req_bus.persist_flag <= '0;
        req_bus.data_value   <= '0;
        rsp_bus.ready        <= 1'b0;
        tx_steady             = 1'b0;
        rx_steady             = 1'b0;
        burst_left            = 3;

        // directed table; the block starts with all 256 slots in use
        // empty table: read and write find nothing
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_READ, 16'h0000, 8'h00, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            reply(odht_pkg::ST_EMPTY, 8'd0, 32'h0, odht_pkg::TYPE_BOOL, 8'h00, 8'h00)});
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_WRITE, 16'h0000, 8'h00, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h5),
            reply(odht_pkg::ST_EMPTY, 8'd0, 32'h0, odht_pkg::TYPE_BOOL, 8'h00, 8'h00)});
        // first entry in slot 0, largest positive value
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_INSERT, 16'h0000, 8'h00, odht_pkg::TYPE_U32, 8'hff, 8'h00,
                32'h7fff_ffff),
            reply(odht_pkg::ST_OK, 8'd0, 32'h7fff_ffff, odht_pkg::TYPE_U32, 8'hff, 8'h00)});
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_READ, 16'h0000, 8'h00, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            reply(odht_pkg::ST_OK, 8'd0, 32'h7fff_ffff, odht_pkg::TYPE_U32, 8'hff, 8'h00)});
        // 8*31+8 = 256 lands on slot 0 too: key is not checked on a read
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_READ, 16'h0008, 8'h08, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            NO_REPLY});
        // foreign index in slot 0 is rejected, even with an unsupported type
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_INSERT, 16'h0008, 8'h08, odht_pkg::TYPE_U8, 8'h11, 8'h22,
                32'h1),
            reply(odht_pkg::ST_COLLISION, 8'd0, 32'h7fff_ffff, odht_pkg::TYPE_U32, 8'hff,
                  8'h00)});
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_INSERT, 16'h0008, 8'h08, odht_pkg::TYPE_UNSUPPORTED, 8'h11,
                8'h22, 32'h1),
            reply(odht_pkg::ST_COLLISION, 8'd0, 32'h7fff_ffff, odht_pkg::TYPE_U32, 8'hff,
                  8'h00)});
        // all-ones key hashes to slot 224; unsupported type leaves it empty
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_INSERT, 16'hffff, 8'hff, odht_pkg::TYPE_UNSUPPORTED, 8'hff,
                8'hff, 32'hffff_ffff),
            reply(odht_pkg::ST_UNSUPPORTED, 8'd224, 32'h0, odht_pkg::TYPE_BOOL, 8'h00,
                  8'h00)});
        rows.push_back('{ROW_KNOWN,
            req(odht_pkg::OP_READ, 16'hffff, 8'hff, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            reply(odht_pkg::ST_EMPTY, 8'd224, 32'h0, odht_pkg::TYPE_BOOL, 8'h00, 8'h00)});
        // signed byte sign-extends, then a write uses the stored type
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'hffff, 8'hff, odht_pkg::TYPE_I8, 8'h00, 8'hff,
                32'h8000_0080),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_WRITE, 16'hffff, 8'hff, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0000_007f),
            NO_REPLY});
        // bool keeps the whole low byte
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h1234, 8'h56, odht_pkg::TYPE_BOOL, 8'h5a, 8'ha5,
                32'h0000_00a5),
            NO_REPLY});
        // same key again: overwritten with a new type
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h1234, 8'h56, odht_pkg::TYPE_I16, 8'h0f, 8'hf0,
                32'h0001_8000),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h00ff, 8'h10, odht_pkg::TYPE_U16, 8'h33, 8'hcc,
                32'hffff_ffff),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h8000, 8'h80, odht_pkg::TYPE_I32, 8'h80, 8'h01,
                32'h8000_0000),
            NO_REPLY});
        // operation code 3 reads
        rows.push_back('{ROW_PREDICT,
            req(OP_ALIAS_READ, 16'h8000, 8'h80, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_WRITE, 16'h0000, 8'h00, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h8000_0000),
            NO_REPLY});
        // a slot count of zero behaves as one slot
        rows.push_back('{ROW_RESIZE,
            req(odht_pkg::OP_INSERT, 16'h0, 8'h0, odht_pkg::TYPE_BOOL, 8'h0, 8'h0, 32'd0),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h0003, 8'h01, odht_pkg::TYPE_U8, 8'h01, 8'h02,
                32'h0000_0042),
            NO_REPLY});
        // same index, other subindex in the one slot: silent overwrite
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h0000, 8'h77, odht_pkg::TYPE_I8, 8'h44, 8'h88,
                32'h0000_00ff),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_READ, 16'habcd, 8'h42, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_WRITE, 16'h7777, 8'h33, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0001_ffff),
            NO_REPLY});
        // a slot count above the depth behaves as the full depth
        rows.push_back('{ROW_RESIZE,
            req(odht_pkg::OP_INSERT, 16'h0, 8'h0, odht_pkg::TYPE_BOOL, 8'h0, 8'h0, 32'd511),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_READ, 16'hffff, 8'hff, odht_pkg::TYPE_BOOL, 8'h00, 8'h00,
                32'h0),
            NO_REPLY});
        rows.push_back('{ROW_PREDICT,
            req(odht_pkg::OP_INSERT, 16'h5555, 8'haa, odht_pkg::TYPE_U32, 8'haa, 8'h55,
                32'h55aa_55aa),
            NO_REPLY});

        // reset held low from time zero, released on a clock edge
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_RESIZE: set_table_size(rows[i].stim.data_value[odht_pkg::CFG_W-1:0]);
                ROW_KNOWN:  issue_request(rows[i].stim, 1'b1, rows[i].known);
                default:    issue_request(rows[i].stim, 1'b0, NO_REPLY);
            endcase
        end

        // random phases over a spread of slot counts; the fourth runs with no idling
        run_random_phase(9'd256, 150, 1'b0, 1'b0);
        run_random_phase(9'd1,    80, 1'b1, 1'b0);
        run_random_phase(9'd13,  120, 1'b1, 1'b0);
        run_random_phase(9'd2,    80, 1'b0, 1'b1);
        run_random_phase(9'd0,    60, 1'b0, 1'b0);
        run_random_phase(9'd511, 120, 1'b0, 1'b0);
        run_random_phase(9'd255, 100, 1'b1, 1'b0);
        run_random_phase(odht_pkg::CFG_W'($urandom_range(3, 256)), 100, 1'b1, 1'b0);

        // let the last replies arrive, then give the block time to show anything extra
        drain_replies();
        repeat (40)
            @(posedge clk);

        $display("covered %0d requests: %0d insert, %0d read, %0d write, %0d code 3, %0d sizes",
                 ops_issued[0] + ops_issued[1] + ops_issued[2] + ops_issued[3],
                 ops_issued[0], ops_issued[1], ops_issued[2], ops_issued[3], size_settings);
        $display("checked %0d replies: %0d new, %0d over, %0d collision, %0d empty, %0d unsup",
                 replies_seen, status_seen[odht_pkg::ST_OK],
                 status_seen[odht_pkg::ST_OVERWRITTEN], status_seen[odht_pkg::ST_COLLISION],
                 status_seen[odht_pkg::ST_EMPTY], status_seen[odht_pkg::ST_UNSUPPORTED]);
        if (fail_count == 0)
            $display("PASS object_dictionary_hash_table");
        else
            $display("FAIL object_dictionary_hash_table");
        $finish;
    end

endmodule
